FILE: rtl/weighted_decision_stump_select_unit_defines.svh
// Assertion macros for the stump select unit checker.
// Needs clk and arst_n visible in the scope where a macro is used.
`ifndef WEIGHTED_DECISION_STUMP_SELECT_UNIT_DEFINES_SVH
`define WEIGHTED_DECISION_STUMP_SELECT_UNIT_DEFINES_SVH

// Clocked assertion, disabled during reset.
`define WDSS_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a property in the next.
`define WDSS_ASSERT_NEXT(label, cond, prop, msg) \
	`WDSS_ASSERT_CLK(label, (cond) |=> (prop), msg)

`endif

FILE: rtl/wdss_pkg.sv
// Shared types, constants and helpers for the stump select unit.
// No dependencies.
package wdss_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int ERR_W     = VAL_W + 1;
	localparam int IDX_OUT_W = 10;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [ERR_W-1:0] err_t;

	localparam val_t ONE_Q         = val_t'(64'd1 << FRAC_BITS);
	localparam val_t VAL_MAX       = '1;
	localparam val_t MAX_ERROR_RST = val_t'(((64'd1 << FRAC_BITS) * 64'd45 + 64'd50) / 64'd100);

	// side/label select of the four sums
	typedef enum logic [1:0] {
		SUM_LEFT_NEG  = 2'b00,
		SUM_LEFT_POS  = 2'b01,
		SUM_RIGHT_NEG = 2'b10,
		SUM_RIGHT_POS = 2'b11
	} sum_sel_t;

	// one closed feature, front to back
	typedef struct packed {
		err_t err_neg;
		err_t err_pos;
		logic last_feature;
	} close_t;

	function automatic val_t sat_add(input val_t a, input val_t b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
	endfunction

endpackage

FILE: rtl/wdss_front.sv
// Front end: takes samples, keeps the four weighted sums of the open feature,
// and on a feature's last sample pushes both polarity errors. Uses wdss_pkg.
module wdss_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  goes_right,
	input  logic                  positive,
	input  wdss_pkg::val_t        weight,
	input  logic                  last_sample_of_feature,
	input  logic                  last_feature,
	input  logic                  q_full,
	output logic                  q_push,
	output wdss_pkg::close_t      q_wdata
);

	wdss_pkg::val_t lp_q, ln_q, rp_q, rn_q;
	wdss_pkg::val_t lp_d, ln_d, rp_d, rn_d;
	wdss_pkg::sum_sel_t sel;
	logic xfer;

	assign in_ready = !q_full;
	assign xfer     = in_valid && in_ready;
	assign sel      = wdss_pkg::sum_sel_t'({goes_right, positive});

	always_comb begin
		lp_d = lp_q;
		ln_d = ln_q;
		rp_d = rp_q;
		rn_d = rn_q;
		case (sel)
			wdss_pkg::SUM_LEFT_NEG:  ln_d = wdss_pkg::sat_add(ln_q, weight);
			wdss_pkg::SUM_LEFT_POS:  lp_d = wdss_pkg::sat_add(lp_q, weight);
			wdss_pkg::SUM_RIGHT_NEG: rn_d = wdss_pkg::sat_add(rn_q, weight);
			wdss_pkg::SUM_RIGHT_POS: rp_d = wdss_pkg::sat_add(rp_q, weight);
			default: ;
		endcase
	end

	assign q_push               = xfer && last_sample_of_feature;
	assign q_wdata.err_neg      = {1'b0, ln_d} + {1'b0, rp_d};
	assign q_wdata.err_pos      = {1'b0, lp_d} + {1'b0, rn_d};
	assign q_wdata.last_feature = last_feature;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			ln_q <= '0;
			rp_q <= '0;
			rn_q <= '0;
		end else if (xfer) begin
			if (last_sample_of_feature) begin
				lp_q <= '0;
				ln_q <= '0;
				rp_q <= '0;
				rn_q <= '0;
			end else begin
				lp_q <= lp_d;
				ln_q <= ln_d;
				rp_q <= rp_d;
				rn_q <= rn_d;
			end
		end
	end

endmodule

FILE: rtl/wdss_queue.sv
// Short register queue of closed features between front and back.
// Uses wdss_pkg.
module wdss_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wdss_pkg::close_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output wdss_pkg::close_t rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wdss_pkg::close_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign rvalid  = (count_q != '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/wdss_back.sv
// Back end: picks the polarity of each closed feature, tracks the running
// best and loads the result register after the final feature. Uses wdss_pkg.
module wdss_back #(
	parameter int MAX_FEATURES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  wdss_pkg::close_t q_data,
	output logic             q_pop,
	input  wdss_pkg::val_t   max_error,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             found,
	output logic [wdss_pkg::IDX_OUT_W-1:0] best_feature,
	output logic             polarity_positive,
	output wdss_pkg::val_t   min_error,
	output logic             accurate_enough
);

	localparam int CNT_W = $clog2(MAX_FEATURES);
	localparam int EXT_W = (CNT_W > wdss_pkg::IDX_OUT_W) ? CNT_W : wdss_pkg::IDX_OUT_W;

	logic [CNT_W-1:0] cnt_q, best_idx_q, nb_idx;
	wdss_pkg::val_t   best_err_q, nb_err;
	logic             best_pol_q, best_found_q, nb_pol, nb_found;
	wdss_pkg::err_t   cand;
	logic             cand_pol, better;
	logic             out_valid_q;
	logic [EXT_W-1:0] idx_ext;

	assign q_pop = q_valid && (!q_data.last_feature || !out_valid_q || out_ready);

	always_comb begin
		if (q_data.err_neg < q_data.err_pos) begin
			cand     = q_data.err_neg;
			cand_pol = 1'b0;
		end else begin
			cand     = q_data.err_pos;
			cand_pol = 1'b1;
		end
		better = cand < {1'b0, best_err_q};
		if (better) begin
			nb_err   = cand[wdss_pkg::VAL_W-1:0];
			nb_pol   = cand_pol;
			nb_idx   = cnt_q;
			nb_found = 1'b1;
		end else begin
			nb_err   = best_err_q;
			nb_pol   = best_pol_q;
			nb_idx   = best_idx_q;
			nb_found = best_found_q;
		end
	end

	assign idx_ext = EXT_W'(nb_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			best_idx_q   <= '0;
			best_err_q   <= wdss_pkg::ONE_Q;
			best_pol_q   <= 1'b0;
			best_found_q <= 1'b0;
		end else if (q_pop) begin
			if (q_data.last_feature) begin
				cnt_q        <= '0;
				best_idx_q   <= '0;
				best_err_q   <= wdss_pkg::ONE_Q;
				best_pol_q   <= 1'b0;
				best_found_q <= 1'b0;
			end else begin
				cnt_q        <= (cnt_q == CNT_W'(MAX_FEATURES - 1)) ? '0 : cnt_q + 1'b1;
				best_idx_q   <= nb_idx;
				best_err_q   <= nb_err;
				best_pol_q   <= nb_pol;
				best_found_q <= nb_found;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && q_data.last_feature) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.last_feature) begin
			found             <= nb_found;
			best_feature      <= idx_ext[wdss_pkg::IDX_OUT_W-1:0];
			polarity_positive <= nb_pol;
			min_error         <= nb_err;
			accurate_enough   <= nb_found && (nb_err <= max_error);
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/weighted_decision_stump_select_unit.sv
// Boosting decision stump selector, top level.
// Instantiates wdss_front, wdss_queue and wdss_back; uses wdss_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one sample per transfer, grouped
//   by feature. last_sample_of_feature closes a feature; with last_feature
//   also set it closes the selection and yields one result.
//   Output channel (out_valid/out_ready) carries the selection result.
//   cfg_we/cfg_wdata write max_error; write only while the block is idle.
// Throughput: one sample per cycle while in_ready is high. The front keeps
//   the sums of the open feature; closed features go through a QUEUE_DEPTH-entry
//   queue to the back, which retires one per cycle unless a result is held.
// Result path: the closing sample's errors enter the queue, and out_valid is
//   registered when the back pops them with nothing ahead of them in the queue.
// Stall: a held result blocks only the final feature of the next selection;
//   once the queue fills behind it, in_ready drops until out_ready takes the
//   result.
// Reset: sums, feature count and best selection clear, max_error returns
//   to 0.45, queue and result register empty.
module weighted_decision_stump_select_unit #(
	parameter int MAX_FEATURES = 1024,
	parameter int QUEUE_DEPTH  = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  goes_right,
	input  logic                  positive,
	input  wdss_pkg::val_t        weight,
	input  logic                  last_sample_of_feature,
	input  logic                  last_feature,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found,
	output logic [wdss_pkg::IDX_OUT_W-1:0] best_feature,
	output logic                  polarity_positive,
	output wdss_pkg::val_t        min_error,
	output logic                  accurate_enough,
	input  logic                  cfg_we,
	input  wdss_pkg::val_t        cfg_wdata
);

	wdss_pkg::val_t   max_error_q;
	wdss_pkg::close_t q_wdata, q_rdata;
	logic             q_push, q_full, q_pop, q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_error_q <= wdss_pkg::MAX_ERROR_RST;
		end else if (cfg_we) begin
			max_error_q <= cfg_wdata;
		end
	end

	wdss_front u_front (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.goes_right             (goes_right),
		.positive               (positive),
		.weight                 (weight),
		.last_sample_of_feature (last_sample_of_feature),
		.last_feature           (last_feature),
		.q_full                 (q_full),
		.q_push                 (q_push),
		.q_wdata                (q_wdata)
	);

	wdss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	wdss_back #(
		.MAX_FEATURES (MAX_FEATURES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_data            (q_rdata),
		.q_pop             (q_pop),
		.max_error         (max_error_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.found             (found),
		.best_feature      (best_feature),
		.polarity_positive (polarity_positive),
		.min_error         (min_error),
		.accurate_enough   (accurate_enough)
	);

endmodule

FILE: rtl/wdss_checker.sv
// Port-level checks for the stump select unit, bound to the top level.
// Uses weighted_decision_stump_select_unit_defines.svh and wdss_pkg.
`include "weighted_decision_stump_select_unit_defines.svh"

module wdss_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  found,
	input logic [wdss_pkg::IDX_OUT_W-1:0] best_feature,
	input logic                  polarity_positive,
	input wdss_pkg::val_t        min_error
);

	`WDSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(min_error) && $stable(best_feature), "result dropped or changed while stalled")

	`WDSS_ASSERT_CLK(a_none_found, out_valid && !found |-> best_feature == '0 && !polarity_positive && min_error == wdss_pkg::ONE_Q, "empty result not in reset form")

	`WDSS_ASSERT_CLK(a_found_below_one, out_valid && found |-> min_error < wdss_pkg::ONE_Q, "found result not below 1.0")

endmodule

bind weighted_decision_stump_select_unit wdss_checker u_wdss_checker (.*);

FILE: bench/testbench.sv
// Self-checking bench for weighted_decision_stump_select_unit: feeds grouped samples,
// predicts the selected stump per selection and compares each transfer on the result side.
// Depends on wdss_pkg and the unit's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FEATURE_LIMIT = 1024;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int PHASES        = 7;

	typedef struct packed {
		logic                           goes_right;
		logic                           positive;
		wdss_pkg::val_t                 weight;
		logic                           last_sample;
		logic                           last_feat;
	} sample_t;

	typedef struct packed {
		logic                           found;
		logic [wdss_pkg::IDX_OUT_W-1:0] feature;
		logic                           pol;
		wdss_pkg::val_t                 err;
		logic                           accurate;
	} stump_t;

	class stump_choice_tracker;
		wdss_pkg::val_t                 side_sum [4];
		logic [wdss_pkg::IDX_OUT_W-1:0] feat_count;
		logic [wdss_pkg::IDX_OUT_W-1:0] best_idx;
		wdss_pkg::val_t                 best_err;
		logic                           best_pol;
		logic                           best_found;
		wdss_pkg::val_t                 max_err;
		stump_t                         pending_choices [$];
		int                             errors;

		function new();
			max_err = wdss_pkg::MAX_ERROR_RST;
			errors  = 0;
			clear_selection();
		endfunction

		function void clear_sums();
			foreach (side_sum[k])
				side_sum[k] = '0;
		endfunction

		function void clear_selection();
			clear_sums();
			feat_count = '0;
			best_err   = wdss_pkg::ONE_Q;
			best_idx   = '0;
			best_pol   = 1'b0;
			best_found = 1'b0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void take_sample(sample_t s);
			wdss_pkg::sum_sel_t      sel;
			logic [wdss_pkg::VAL_W:0] wide;
			wdss_pkg::err_t          err_neg;
			wdss_pkg::err_t          err_pos;
			wdss_pkg::err_t          cand;
			logic                    cand_pol;
			stump_t                  r;
			sel  = wdss_pkg::sum_sel_t'({s.goes_right, s.positive});
			wide = {1'b0, side_sum[sel]} + {1'b0, s.weight};
			side_sum[sel] = wide[wdss_pkg::VAL_W] ? '1 : wide[wdss_pkg::VAL_W-1:0];
			if (!s.last_sample)
				return;
			err_neg = wdss_pkg::err_t'(side_sum[wdss_pkg::SUM_LEFT_NEG])
				+ wdss_pkg::err_t'(side_sum[wdss_pkg::SUM_RIGHT_POS]);
			err_pos = wdss_pkg::err_t'(side_sum[wdss_pkg::SUM_LEFT_POS])
				+ wdss_pkg::err_t'(side_sum[wdss_pkg::SUM_RIGHT_NEG]);
			if (err_neg < err_pos) begin
				cand     = err_neg;
				cand_pol = 1'b0;
			end else begin
				cand     = err_pos;
				cand_pol = 1'b1;
			end
			if (cand < wdss_pkg::err_t'(best_err)) begin
				best_err   = wdss_pkg::val_t'(cand);
				best_pol   = cand_pol;
				best_idx   = feat_count;
				best_found = 1'b1;
			end
			clear_sums();
			feat_count = (feat_count == FEATURE_LIMIT - 1) ? '0 : feat_count + 1'b1;
			if (!s.last_feat)
				return;
			if (best_found)
				r = '{1'b1, best_idx, best_pol, best_err, best_err <= max_err};
			else
				r = '{1'b0, '0, 1'b0, wdss_pkg::ONE_Q, 1'b0};
			pending_choices = {pending_choices, r};
			clear_selection();
		endfunction

		function void check_choice(stump_t got);
			stump_t want;
			if (pending_choices.size() == 0) begin
				flag($sformatf("unexpected result found=%0d feature=%0d pol=%0d error=%0d acc=%0d",
					got.found, got.feature, got.pol, got.err, got.accurate));
				return;
			end
			want = pending_choices.pop_front();
			if (got.found !== want.found || got.feature !== want.feature ||
			    got.pol !== want.pol || got.err !== want.err ||
			    got.accurate !== want.accurate)
				flag($sformatf({"mismatch: expected found=%0d feature=%0d pol=%0d error=%0d acc=%0d",
					", got found=%0d feature=%0d pol=%0d error=%0d acc=%0d"},
					want.found, want.feature, want.pol, want.err, want.accurate,
					got.found, got.feature, got.pol, got.err, got.accurate));
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n                 = 1'b0;
	logic                           in_valid               = 1'b0;
	logic                           in_ready;
	logic                           goes_right             = 1'b0;
	logic                           positive               = 1'b0;
	wdss_pkg::val_t                 weight                 = '0;
	logic                           last_sample_of_feature = 1'b0;
	logic                           last_feature           = 1'b0;
	logic                           out_valid;
	logic                           out_ready              = 1'b0;
	logic                           found;
	logic [wdss_pkg::IDX_OUT_W-1:0] best_feature;
	logic                           polarity_positive;
	wdss_pkg::val_t                 min_error;
	logic                           accurate_enough;
	logic                           cfg_we                 = 1'b0;
	wdss_pkg::val_t                 cfg_wdata              = '0;

	stump_choice_tracker  tracker;
	int                   cycle_count  = 0;
	int                   ready_mode   = 1;
	int                   stall_left   = 0;
	int                   burst_left   = 0;
	int                   random_items = 0;
	bit                   valid_up     = 1'b0;

	weighted_decision_stump_select_unit #(
		.MAX_FEATURES(FEATURE_LIMIT)
	) i_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.goes_right             (goes_right),
		.positive               (positive),
		.weight                 (weight),
		.last_sample_of_feature (last_sample_of_feature),
		.last_feature           (last_feature),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.found                  (found),
		.best_feature           (best_feature),
		.polarity_positive      (polarity_positive),
		.min_error              (min_error),
		.accurate_enough        (accurate_enough),
		.cfg_we                 (cfg_we),
		.cfg_wdata              (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: mode 0 always ready, 1 random, 2 mostly ready with long stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: begin
					out_ready <= ($urandom_range(0, 3) != 0);
					if ($urandom_range(0, 31) == 0)
						stall_left <= $urandom_range(2, 12);
				end
				default: begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_left <= $urandom_range(5, 40);
				end
			endcase
		end
	end

	// inputs only change at rising edges, so the negedge view is what the next edge takes
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			tracker.check_choice('{found, best_feature, polarity_positive, min_error,
				accurate_enough});
	end

	task automatic push_sample(input logic gr, input logic pos, input wdss_pkg::val_t w,
			input logic ls, input logic lf);
		int gap;
		in_valid               <= 1'b1;
		valid_up               = 1'b1;
		goes_right             <= gr;
		positive               <= pos;
		weight                 <= w;
		last_sample_of_feature <= ls;
		last_feature           <= lf;
		do
			@(negedge clk);
		while (in_ready !== 1'b1);
		@(posedge clk);
		tracker.take_sample('{gr, pos, w, ls, lf});
		burst_left--;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(40, 200);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap        = $urandom_range(0, 8);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				valid_up = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		while (tracker.pending_choices.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_max_error(input wdss_pkg::val_t v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.max_err = v;
	endtask

	function automatic wdss_pkg::val_t pick_weight(input int unsigned scale);
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return '1;
			2:       return wdss_pkg::ONE_Q;
			3:       return wdss_pkg::val_t'($urandom_range(0, 131071));
			default: return wdss_pkg::val_t'($urandom_range(0, scale));
		endcase
	endfunction

	task automatic run_selection(input int n_feats, input int max_samples,
			input int unsigned scale);
		int   n;
		logic closing;
		logic lf;
		for (int f = 0; f < n_feats; f++) begin
			n = $urandom_range(1, max_samples);
			for (int j = 0; j < n; j++) begin
				closing = (j == n - 1);
				lf      = closing ? (f == n_feats - 1) : ($urandom_range(0, 7) == 0);
				push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					pick_weight(scale), closing, lf);
				random_items++;
			end
		end
	endtask

	initial begin
		int             phase_goal;
		int unsigned    scale;
		wdss_pkg::val_t limit_val;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing found, with a final-feature mark on a non-closing sample
		push_sample(1'b0, 1'b1, wdss_pkg::ONE_Q, 1'b0, 1'b1);
		push_sample(1'b0, 1'b0, wdss_pkg::ONE_Q, 1'b1, 1'b1);
		// tie picks +1, equal error keeps the earlier feature, then a strictly smaller one
		push_sample(1'b0, 1'b1, wdss_pkg::val_t'(20000), 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, wdss_pkg::val_t'(20000), 1'b1, 1'b0);
		push_sample(1'b1, 1'b0, wdss_pkg::val_t'(20000), 1'b0, 1'b0);
		push_sample(1'b1, 1'b1, wdss_pkg::val_t'(20000), 1'b1, 1'b0);
		push_sample(1'b0, 1'b1, wdss_pkg::val_t'(30000), 1'b0, 1'b0);
		push_sample(1'b1, 1'b1, wdss_pkg::val_t'(1000), 1'b1, 1'b1);
		// saturated sums, error above 1.0, then zero weights and zero error
		push_sample(1'b1, 1'b1, '1, 1'b0, 1'b0);
		push_sample(1'b1, 1'b1, '1, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, '1, 1'b0, 1'b0);
		push_sample(1'b0, 1'b1, '1, 1'b0, 1'b0);
		push_sample(1'b1, 1'b0, wdss_pkg::val_t'(1), 1'b1, 1'b0);
		push_sample(1'b0, 1'b1, wdss_pkg::val_t'(40000), 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, '0, 1'b0, 1'b0);
		push_sample(1'b1, 1'b0, '0, 1'b1, 1'b1);
		// just above and exactly at the threshold
		push_sample(1'b0, 1'b1, wdss_pkg::MAX_ERROR_RST + 1'b1, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, wdss_pkg::MAX_ERROR_RST + 1'b1, 1'b1, 1'b1);
		push_sample(1'b0, 1'b1, wdss_pkg::MAX_ERROR_RST, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, wdss_pkg::MAX_ERROR_RST, 1'b1, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			ready_mode = ph % 3;
			case (ph)
				0:       limit_val = '0;
				1:       limit_val = '1;
				2:       limit_val = wdss_pkg::ONE_Q;
				3:       limit_val = wdss_pkg::val_t'($urandom_range(0, 65536));
				4:       limit_val = wdss_pkg::val_t'(1);
				5:       limit_val = wdss_pkg::val_t'($urandom_range(0, 131071));
				default: limit_val = wdss_pkg::MAX_ERROR_RST;
			endcase
			write_max_error(limit_val);
			phase_goal = random_items + RANDOM_ITEMS / PHASES;
			while (random_items < phase_goal) begin
				case ($urandom_range(0, 2))
					0:       scale = 8000;
					1:       scale = 30000;
					default: scale = 131071;
				endcase
				run_selection($urandom_range(1, 6), $urandom_range(1, 6), scale);
			end
		end
		settle();

		if (tracker.pending_choices.size() != 0)
			tracker.flag("results still outstanding at end of run");
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wdss_pkg.sv
rtl/wdss_front.sv
rtl/wdss_queue.sv
rtl/wdss_back.sv
rtl/weighted_decision_stump_select_unit.sv
rtl/wdss_checker.sv
bench/testbench.sv
